@@ rtl/mtet_pkg.sv @@
// Shared constants and types for the multi-turn encoder tracker.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package mtet_pkg;

  // Field widths
  localparam int RAW_W   = 13;
  localparam int TURN_W  = 24;
  localparam int POS_W   = 37;
  localparam int ANG_W   = 43;
  localparam int RATE_W  = 14;

  // Unwrap thresholds and scaling
  localparam int WRAP_LIMIT      = 6400;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int ANGLE_SCALE     = 45;    // 360 deg * 1024 / 8192 counts

  // Moving-average depth default and reciprocal precision
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int RECIP_SHIFT       = 32;
  localparam int RECIP_W           = RECIP_SHIFT + 1;

  // Tracker state as seen by the scaling stage
  typedef struct packed {
    logic        [RAW_W-1:0]  raw;
    logic signed [TURN_W-1:0] turns;
    logic signed [RATE_W-1:0] rate;
  } track_state_t;

endpackage

`default_nettype wire

@@ rtl/multi_turn_encoder_tracker.sv @@
// Multi-turn encoder tracker: unwrap, angle scaling and moving-average rate.
// Input transactions reach the result through both stages in order; throughput 1 item per cycle while out_stall is low.
// Stage 1 is the tracker state itself, stage 2 the result register (two multipliers).
// Synchronous reset clears turns, previous reading, rate history, sum and bias.
// Depends on mtet_pkg, mtet_unwrap and mtet_scale.
`timescale 1ns / 1ps
`default_nettype none

module multi_turn_encoder_tracker #(
  parameter int HISTORY_DEPTH = mtet_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [mtet_pkg::RAW_W-1:0]  cfg_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [mtet_pkg::RAW_W-1:0]  raw_position,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [mtet_pkg::TURN_W-1:0] turn_count,
  output logic signed      [mtet_pkg::POS_W-1:0]  continuous_position,
  output logic signed      [mtet_pkg::ANG_W-1:0]  angle_fixed,
  output logic signed      [mtet_pkg::RATE_W-1:0] step_rate,
  output logic signed      [mtet_pkg::RATE_W-1:0] mean_rate
);

  localparam int SUM_W = mtet_pkg::RATE_W + $clog2(HISTORY_DEPTH);

  logic                       s1_valid;
  logic                       s1_load;
  logic                       s2_load;
  logic [mtet_pkg::RAW_W-1:0] angle_bias;
  mtet_pkg::track_state_t     state;
  logic signed [SUM_W-1:0]    rate_sum;

  // Bias register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_bias <= '0;
    end else if (cfg_valid && cfg_ready) begin
      angle_bias <= cfg_data;
    end
  end

  // Pipeline flow control
  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  mtet_unwrap #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SUM_W         (SUM_W)
  ) u_unwrap (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_load),
    .raw_in   (raw_position),
    .state    (state),
    .rate_sum (rate_sum)
  );

  mtet_scale #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SUM_W         (SUM_W)
  ) u_scale (
    .clk                 (clk),
    .load                (s2_load),
    .state               (state),
    .rate_sum            (rate_sum),
    .angle_bias          (angle_bias),
    .turn_count          (turn_count),
    .continuous_position (continuous_position),
    .angle_fixed         (angle_fixed),
    .step_rate           (step_rate),
    .mean_rate           (mean_rate)
  );

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted transaction lost before result stage");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step_rate >= -14'sd6400 && step_rate <= 14'sd6400))
    else $error("corrected rate out of range");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mean_rate >= -14'sd6400 && mean_rate <= 14'sd6400))
    else $error("mean rate out of range");

endmodule

`default_nettype wire

@@ rtl/mtet_unwrap.sv @@
// Turn unwrap, rate correction and rate history shift line with running sum.
// Depends on mtet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtet_unwrap #(
  parameter int HISTORY_DEPTH = mtet_pkg::HISTORY_DEPTH_DEF,
  parameter int SUM_W         = mtet_pkg::RATE_W + $clog2(HISTORY_DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire logic        [mtet_pkg::RAW_W-1:0] raw_in,
  output mtet_pkg::track_state_t                 state,
  output logic signed      [SUM_W-1:0]           rate_sum
);

  logic        [mtet_pkg::RAW_W-1:0]  previous_reading;
  logic signed [mtet_pkg::TURN_W-1:0] turns;
  logic signed [mtet_pkg::RATE_W-1:0] rate_history [HISTORY_DEPTH];

  logic signed [mtet_pkg::RATE_W-1:0] jump;
  logic signed [mtet_pkg::RATE_W-1:0] rate_next;
  logic signed [mtet_pkg::TURN_W-1:0] turns_next;
  logic signed [SUM_W-1:0]            rate_sum_next;

  // Jump from previous reading and wrap correction
  always_comb begin
    jump = $signed({1'b0, raw_in}) - $signed({1'b0, previous_reading});
    if (jump < -mtet_pkg::RATE_W'(mtet_pkg::WRAP_LIMIT)) begin
      turns_next = turns + mtet_pkg::TURN_W'(1);
      rate_next  = jump + mtet_pkg::RATE_W'(mtet_pkg::COUNTS_PER_TURN);
    end else if (jump > mtet_pkg::RATE_W'(mtet_pkg::WRAP_LIMIT)) begin
      turns_next = turns - mtet_pkg::TURN_W'(1);
      rate_next  = jump - mtet_pkg::RATE_W'(mtet_pkg::COUNTS_PER_TURN);
    end else begin
      turns_next = turns;
      rate_next  = jump;
    end
    // Oldest entry leaves the window as the new rate enters
    rate_sum_next = rate_sum
                  - SUM_W'(rate_history[HISTORY_DEPTH-1])
                  + SUM_W'(rate_next);
  end

  // State registers; history taps shift by one on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_reading <= '0;
      turns            <= '0;
      rate_sum         <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        rate_history[i] <= '0;
      end
    end else if (load) begin
      previous_reading <= raw_in;
      turns            <= turns_next;
      rate_sum         <= rate_sum_next;
      rate_history[0]  <= rate_next;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        rate_history[i] <= rate_history[i-1];
      end
    end
  end

  // Newest tap holds the latest corrected rate
  assign state.raw   = previous_reading;
  assign state.turns = turns;
  assign state.rate  = rate_history[0];

endmodule

`default_nettype wire

@@ rtl/mtet_scale.sv @@
// Output stage: continuous position, fixed-point angle and mean rate.
// Depends on mtet_pkg; fed by mtet_unwrap.
`timescale 1ns / 1ps
`default_nettype none

module mtet_scale #(
  parameter int HISTORY_DEPTH = mtet_pkg::HISTORY_DEPTH_DEF,
  parameter int SUM_W         = mtet_pkg::RATE_W + $clog2(HISTORY_DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                load,
  input  wire mtet_pkg::track_state_t              state,
  input  wire logic signed [SUM_W-1:0]             rate_sum,
  input  wire logic        [mtet_pkg::RAW_W-1:0]   angle_bias,
  output logic signed      [mtet_pkg::TURN_W-1:0]  turn_count,
  output logic signed      [mtet_pkg::POS_W-1:0]   continuous_position,
  output logic signed      [mtet_pkg::ANG_W-1:0]   angle_fixed,
  output logic signed      [mtet_pkg::RATE_W-1:0]  step_rate,
  output logic signed      [mtet_pkg::RATE_W-1:0]  mean_rate
);

  localparam int PROD_W = SUM_W + mtet_pkg::RECIP_W;
  // ceil(2^32 / depth): exact truncating quotient for sums below 2^26
  localparam logic [mtet_pkg::RECIP_W-1:0] RECIP = mtet_pkg::RECIP_W'(
    ((64'd1 << mtet_pkg::RECIP_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  logic signed [mtet_pkg::POS_W-1:0]  pos;
  logic signed [mtet_pkg::ANG_W-1:0]  ang_base;
  logic signed [mtet_pkg::ANG_W-1:0]  ang;
  logic                               sum_neg;
  logic        [SUM_W-1:0]            sum_mag;
  logic        [PROD_W-1:0]           prod;
  logic        [mtet_pkg::RATE_W-1:0] quot;
  logic signed [mtet_pkg::RATE_W-1:0] mean;

  // Position is turns:raw; angle is (position - bias) * 45
  always_comb begin
    pos      = $signed({state.turns, state.raw});
    ang_base = mtet_pkg::ANG_W'(pos) - $signed(mtet_pkg::ANG_W'(angle_bias));
    ang      = ang_base * mtet_pkg::ANG_W'(mtet_pkg::ANGLE_SCALE);
  end

  // Mean by reciprocal multiply on the magnitude, truncating toward zero
  always_comb begin
    sum_neg = rate_sum[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-rate_sum) : SUM_W'(rate_sum);
    prod    = PROD_W'(sum_mag) * PROD_W'(RECIP);
    quot    = prod[mtet_pkg::RECIP_SHIFT +: mtet_pkg::RATE_W];
    mean    = sum_neg ? $signed(-quot) : $signed(quot);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      turn_count          <= state.turns;
      continuous_position <= pos;
      angle_fixed         <= ang;
      step_rate           <= state.rate;
      mean_rate           <= mean;
    end
  end

endmodule

`default_nettype wire

@@ test/multi_turn_encoder_tracker_test.sv @@
// Self-checking testbench for multi_turn_encoder_tracker: directed readings, then random
// walks, wrap jumps and noise under several angle biases. Checks against a local model.
// Depends on mtet_pkg and the tracker RTL.
`timescale 1ns / 1ps

module multi_turn_encoder_tracker_test;
  import mtet_pkg::*;

  localparam int HIST_DEPTH  = HISTORY_DEPTH_DEF;
  localparam int TURN_ANGLE  = ANGLE_SCALE * COUNTS_PER_TURN;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_TAIL  = 4;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 230;
  localparam int DIR_ROWS    = 16;

  typedef struct packed {
    logic signed [TURN_W-1:0] turns;
    logic signed [POS_W-1:0]  pos;
    logic signed [ANG_W-1:0]  angle;
    logic signed [RATE_W-1:0] rate;
    logic signed [RATE_W-1:0] mean;
  } track_result_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             known;
    track_result_t    want;
  } dir_row_t;

  // Directed readings. Only the first four rows carry a typed result (bias 0):
  // first sample above the wrap limit counts a turn down, then back through zero.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{13'd8191, 1'b1, '{-24'sd1, -37'sd1, -43'sd45, -14'sd1, 14'sd0}},
    '{13'd0,    1'b1, '{24'sd0, 37'sd0, 43'sd0, 14'sd1, 14'sd0}},
    '{13'd6400, 1'b1, '{24'sd0, 37'sd6400, 43'sd288000, 14'sd6400, 14'sd800}},
    '{13'd0,    1'b1, '{24'sd0, 37'sd0, 43'sd0, -14'sd6400, 14'sd0}},
    '{13'd6401, 1'b0, '0},   // jump just past the limit: turn down
    '{13'd1,    1'b0, '0},   // jump of exactly -6400: no turn
    '{13'd6401, 1'b0, '0},   // jump of exactly +6400: no turn
    '{13'd0,    1'b0, '0},   // jump of -6401: turn up
    '{13'd8191, 1'b0, '0},
    '{13'd8190, 1'b0, '0},
    '{13'h1555, 1'b0, '0},
    '{13'h0AAA, 1'b0, '0},
    '{13'h1000, 1'b0, '0},
    '{13'h0FFF, 1'b0, '0},
    '{13'd1,    1'b0, '0},
    '{13'd0,    1'b0, '0}
  };

  int phase_drift [PHASES] = '{0, 1200, -1200, 500, -800};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [RAW_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RAW_W-1:0]     raw_position = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [TURN_W-1:0] turn_count;
  logic signed [POS_W-1:0]  continuous_position;
  logic signed [ANG_W-1:0]  angle_fixed;
  logic signed [RATE_W-1:0] step_rate;
  logic signed [RATE_W-1:0] mean_rate;

  // Local copy of the tracker state and the bias register
  logic [RAW_W-1:0]         prev_reading = '0;
  logic signed [TURN_W-1:0] turn_ctr = '0;
  logic [RAW_W-1:0]         bias_reg = '0;
  int                       rate_hist [HIST_DEPTH];
  int                       hist_pos = 0;
  int                       rate_sum = 0;

  track_result_t pending_tracks [$];
  int mismatch_count = 0;
  int readings_sent = 0;
  int results_seen = 0;
  int turns_up = 0;
  int turns_down = 0;
  int burst_left = 0;

  // Receiver stall control
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          stall_tick = 0;
  logic [15:0] stall_pat = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Single configuration register: angle_bias
  multi_turn_encoder_tracker #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .raw_position       (raw_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .turn_count         (turn_count),
    .continuous_position(continuous_position),
    .angle_fixed        (angle_fixed),
    .step_rate          (step_rate),
    .mean_rate          (mean_rate)
  );

  // Unwrap one reading, update the rate history and form the expected result
  function automatic track_result_t track_reading(input logic [RAW_W-1:0] raw);
    int            jump;
    int            rate;
    longint        t;
    track_result_t res;
    jump = int'(raw) - int'(prev_reading);
    if (jump < -WRAP_LIMIT) begin
      turn_ctr = turn_ctr + 24'sd1;
      rate = jump + COUNTS_PER_TURN;
      turns_up++;
    end else if (jump > WRAP_LIMIT) begin
      turn_ctr = turn_ctr - 24'sd1;
      rate = jump - COUNTS_PER_TURN;
      turns_down++;
    end else begin
      rate = jump;
    end
    prev_reading = raw;
    t = longint'(turn_ctr);
    res.turns = turn_ctr;
    res.pos   = POS_W'(longint'(raw) + t * COUNTS_PER_TURN);
    res.angle = ANG_W'((longint'(raw) - longint'(bias_reg)) * ANGLE_SCALE + t * TURN_ANGLE);
    // running sum over the ring; unwritten entries are zero
    rate_sum = rate_sum - rate_hist[hist_pos] + rate;
    rate_hist[hist_pos] = rate;
    hist_pos = (hist_pos + 1) % HIST_DEPTH;
    res.rate = RATE_W'(rate);
    res.mean = RATE_W'(rate_sum / HIST_DEPTH);
    return res;
  endfunction

  // Next random reading: mostly a drifting walk, plus wrap-limit jumps and noise
  function automatic logic [RAW_W-1:0] pick_reading(input int drift);
    int               sel;
    int               step;
    logic [RAW_W-1:0] r;
    sel = $urandom_range(0, 99);
    if (sel < 82) begin
      if (sel < 70) begin
        step = drift + int'($urandom_range(0, 600)) - 300;
      end else begin
        step = ($urandom_range(0, 4) == 4) ? COUNTS_PER_TURN - 1
                                           : WRAP_LIMIT - 1 + int'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) step = -step;
      end
      step = int'(prev_reading) + step;
      r = step[RAW_W-1:0];
    end else if (sel < 92) begin
      r = RAW_W'($urandom_range(0, COUNTS_PER_TURN - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: r = '0;
        1: r = '1;
        2: r = 13'h1555;
        default: r = 13'h0AAA;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at result %0d: %s got %0d, want %0d", results_seen, what, got, want);
  endtask

  task automatic check_result();
    track_result_t got;
    track_result_t want;
    got = {turn_count, continuous_position, angle_fixed, step_rate, mean_rate};
    if (pending_tracks.size() == 0) begin
      report_mismatch("result with nothing pending, turn_count", got.turns, 0);
      return;
    end
    want = pending_tracks.pop_front();
    results_seen++;
    if (got.turns !== want.turns) report_mismatch("turn_count", got.turns, want.turns);
    if (got.pos !== want.pos) report_mismatch("continuous_position", got.pos, want.pos);
    if (got.angle !== want.angle) report_mismatch("angle_fixed", got.angle, want.angle);
    if (got.rate !== want.rate) report_mismatch("step_rate", got.rate, want.rate);
    if (got.mean !== want.mean) report_mismatch("mean_rate", got.mean, want.mean);
  endtask

  // Offer one reading in bursts with random gaps; predict once it is taken
  task automatic send_reading(input logic [RAW_W-1:0] raw, input logic known,
                              input track_result_t want);
    int            gap;
    track_result_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    raw_position <= raw;
    do @(posedge clk); while (in_stall);
    pred = track_reading(raw);
    pending_tracks.push_back(known ? want : pred);
    readings_sent++;
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_bias(input logic [RAW_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bias_reg = value;
  endtask

  // Result side: check every transaction, stall on a shifting pattern or a long hold
  always @(posedge clk) begin
    if (out_valid && !out_stall) check_result();
    if (hold_left > 0) begin
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (stall_tick == 0) begin
      stall_tick = 48;
      case ($urandom_range(0, 3))
        0: stall_pat = '0;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'($urandom & $urandom & $urandom);
      endcase
    end
    stall_tick--;
    out_stall <= (hold_left > 0) || stall_pat[stall_tick % 16];
  end

  // Watchdog: ends the run when no transaction happens for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Main sequence
  initial begin
    logic [RAW_W-1:0] phase_bias [PHASES];
    phase_bias = '{13'd8191, 13'h1555, RAW_W'($urandom_range(1, 8190)), 13'h0AAA, 13'd0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_bias('0);

    foreach (dir_rows[i]) send_reading(dir_rows[i].raw, dir_rows[i].known, dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_bias(phase_bias[p]);
      // long hold on the result side while readings keep coming
      if (p == 1) holds_asked++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_reading(pick_reading(phase_drift[p]), 1'b0, '0);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d readings, %0d results checked, %0d turns up, %0d turns down",
             readings_sent, results_seen, turns_up, turns_down);
    $display("run: %0d bias settings from 0 to 8191, final turn count %0d",
             PHASES + 1, turn_ctr);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ multi_turn_encoder_tracker.f @@
rtl/mtet_pkg.sv
rtl/mtet_unwrap.sv
rtl/mtet_scale.sv
rtl/multi_turn_encoder_tracker.sv
test/multi_turn_encoder_tracker_test.sv
